>>> rtl/ldtu_pkg.sv
// shared types and constants for the link distance table update unit
package ldtu_pkg;

  // distance arithmetic
  localparam int SCALE_RANGE = 100;
  localparam int DIST_MAX    = 255;
  localparam int DIST_BITS   = 8;
  localparam int QUOT_BITS   = 8;
  localparam int STEP_BITS   = $clog2(QUOT_BITS);
  localparam int CNT_BITS    = 16;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_TOLERANCE     = 1'b0;
  localparam logic REG_FWD_THRESHOLD = 1'b1;

  // configuration reset values
  localparam logic [DIST_BITS-1:0] TOLERANCE_RST     = 8'd10;
  localparam logic [DIST_BITS-1:0] FWD_THRESHOLD_RST = 8'd128;

  // status from the divider back to the sequencer
  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quotient;
  } div_status_t;

endpackage

>>> rtl/link_distance_table_update_unit.sv
// top level of the link distance table update unit
//
// one word in, one word out. a word is taken on start while busy is low and
// busy stays high until its result has been shown. after the accepting edge an
// item goes through these steps in order: form the scaled numerator and read
// the table, load the divider, run the restoring divider that yields one
// quotient bit per cycle, let the divider flag done, compare and write the
// table, and show the result with the done strobe. a new word is taken only
// once the result has been shown. the one divider serves both ratio branches.
// the result sits on the output ports for the single cycle that done is high
// and the receiver cannot stall it. the distance table comes out of reset
// cleared at once (per-entry valid bits), so no sweep is needed. tolerance and
// forward_threshold are written over the apb port at byte addresses 0 and 4
// and are meant to be changed only while busy is low.
module link_distance_table_update_unit import ldtu_pkg::*; #(
  parameter int HOST_COUNT = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  host_index,
  input  logic [47:0] peer_mac,
  input  logic [15:0] sent_count,
  input  logic [15:0] received_count,
  // result side
  output logic        done,
  output logic [7:0]  link_distance,
  output logic        table_updated,
  output logic [47:0] report_mac,
  output logic [7:0]  stored_distance,
  output logic [31:0] forward_count,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // counts are used in their low COUNT_BITS bits, never more than the port has
  localparam int CW    = (COUNT_BITS < CNT_BITS) ? COUNT_BITS : CNT_BITS;
  localparam int NW    = CW + QUOT_BITS;
  localparam int IDX_W = $clog2(HOST_COUNT);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [DIST_BITS-1:0] tolerance;
  logic [DIST_BITS-1:0] forward_threshold;
  logic                 cfg_write;

  // latched item
  logic [IDX_W-1:0] host;
  logic             host_in_range;
  logic [CW-1:0]    sent;
  logic [CW-1:0]    recv;
  logic             recv_ge;      // received >= sent: scaled-ratio branch
  logic             both_zero;    // nothing received and nothing sent
  logic [47:0]      mac;

  // divider operands
  logic [NW-1:0]    numer;
  logic [CW-1:0]    denom;
  logic             div_start;
  div_status_t      div_status;

  // distance table and its valid bits
  logic [DIST_BITS-1:0] dist_mem [HOST_COUNT];
  logic [HOST_COUNT-1:0] entry_valid;
  logic [DIST_BITS-1:0] mem_rd;
  logic                 valid_rd;

  // update stage logic
  logic [DIST_BITS-1:0] quot;
  logic [DIST_BITS-1:0] distance;
  logic [DIST_BITS-1:0] old_dist;
  logic [DIST_BITS-1:0] diff;
  logic                 replace;

  // apb: always ready, write on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance         <= TOLERANCE_RST;
      forward_threshold <= FWD_THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_TOLERANCE:     tolerance         <= pwdata[DIST_BITS-1:0];
        REG_FWD_THRESHOLD: forward_threshold <= pwdata[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOLERANCE:     prdata = 32'(tolerance);
      REG_FWD_THRESHOLD: prdata = 32'(forward_threshold);
      default:           prdata = '0;
    endcase
  end

  // sequencer
  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (div_status.done) state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= (state == ST_MUL);
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      host          <= IDX_W'(host_index);
      host_in_range <= (32'(host_index) < HOST_COUNT);
      sent          <= sent_count[CW-1:0];
      recv          <= received_count[CW-1:0];
      recv_ge       <= (received_count[CW-1:0] >= sent_count[CW-1:0]);
      both_zero     <= (received_count[CW-1:0] == '0) && (sent_count[CW-1:0] == '0);
      mac           <= peer_mac;
    end
  end

  // scaled numerator: sent*100 over received, or received*155 over sent
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      if (recv_ge) begin
        numer <= NW'(sent) * NW'(SCALE_RANGE);
        denom <= recv;
      end else begin
        numer <= NW'(recv) * NW'(DIST_MAX - SCALE_RANGE);
        denom <= sent;
      end
    end
  end

  ldtu_divider #(
    .DEN_BITS (CW)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .numerator   (numer),
    .denominator (denom),
    .status      (div_status)
  );

  // table read during the multiply cycle, write in the update cycle
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      mem_rd <= dist_mem[host];
    end
    if (state == ST_UPD && host_in_range && replace) begin
      dist_mem[host] <= distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_rd    <= 1'b0;
    end else begin
      if (state == ST_MUL) begin
        valid_rd <= entry_valid[host];
      end
      if (state == ST_UPD && host_in_range && replace) begin
        entry_valid[host] <= 1'b1;
      end
    end
  end

  // distance from the quotient
  assign quot = div_status.quotient;

  always_comb begin
    if (both_zero) begin
      distance = DIST_BITS'(DIST_MAX);
    end else if (recv_ge) begin
      distance = quot;
    end else if (quot == DIST_BITS'(DIST_MAX)) begin
      distance = DIST_BITS'(1);
    end else begin
      distance = DIST_BITS'(DIST_MAX) - quot;
    end
  end

  // an unset entry reads as zero and is always replaced
  assign old_dist = valid_rd ? mem_rd : '0;
  assign diff     = (distance >= old_dist) ? (distance - old_dist) : (old_dist - distance);
  assign replace  = (diff >= tolerance) || (old_dist == '0);

  // result registers and the saturating forward counter
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      link_distance   <= distance;
      table_updated   <= host_in_range & replace;
      if (!host_in_range) begin
        stored_distance <= '0;
      end else if (replace) begin
        stored_distance <= distance;
      end else begin
        stored_distance <= old_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_count <= '0;
    end else if (state == ST_UPD && distance < forward_threshold && forward_count != '1) begin
      forward_count <= forward_count + 1'b1;
    end
  end

  assign report_mac = mac;
  assign done       = (state == ST_OUT);

endmodule

>>> rtl/ldtu_divider.sv
// restoring shift-subtract divider, one quotient bit per cycle
module ldtu_divider import ldtu_pkg::*; #(
  parameter int DEN_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DEN_BITS+QUOT_BITS-1:0] numerator,
  input  logic [DEN_BITS-1:0]           denominator,
  output div_status_t                   status
);

  localparam int NUM_BITS = DEN_BITS + QUOT_BITS;

  logic [NUM_BITS-1:0]  rem;
  logic [NUM_BITS-1:0]  dsh;
  logic [QUOT_BITS-1:0] quot;
  logic [STEP_BITS-1:0] step;
  logic                 running;
  logic                 done;
  logic                 fits;

  // shared compare and subtract
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEP_BITS'(QUOT_BITS - 1);
      end else if (running) begin
        step <= step - 1'b1;
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numerator;
      dsh  <= NUM_BITS'(denominator) << (QUOT_BITS - 1);
      quot <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QUOT_BITS-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign status.done     = done;
  assign status.quotient = quot;

endmodule

>>> rtl/ldtu_checker.sv
// port-level checks for the link distance table update unit
module ldtu_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] link_distance,
  input logic       table_updated,
  input logic [7:0] stored_distance
);

  // an accepted word keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // the result is shown while busy and the block frees up right after
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 (!busy && !done))
    else $error("done not followed by idle");

  // a replaced entry holds the distance just computed
  a_update_value: assert property (@(posedge clk) disable iff (rst)
    done && table_updated |-> stored_distance == link_distance)
    else $error("replaced entry differs from distance");

  // a result that keeps a nonzero stored entry follows a busy cycle
  a_update_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !table_updated && stored_distance != 8'd0 |-> $past(busy))
    else $error("result without work");

  // reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("not idle after reset");

endmodule

bind link_distance_table_update_unit ldtu_checker u_ldtu_checker (.*);
